FILE: rtl/cdm_pkg.sv
`timescale 1ns / 1ps

package cdm_pkg;

  // sample and delay line geometry
  localparam int SAMPLE_W    = 24;
  localparam int DELAY_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int CNT_W       = $clog2(DELAY_DEPTH + 1);

  // fixed point formats
  localparam int DLY_W      = 18;
  localparam int DLY_FRAC   = 8;
  localparam int DINT_W     = DLY_W - DLY_FRAC + 1;
  localparam int PHASE_W    = 25;
  localparam int PHASE_FRAC = 22;
  localparam int STEP_W     = 21;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN      = 3'd4;

  localparam logic [DLY_W-1:0]  RST_BASE_DELAY    = 18'd74035;
  localparam logic [DLY_W-1:0]  RST_MOD_DEPTH     = 18'd66632;
  localparam logic [STEP_W-1:0] RST_LFO_STEP      = 21'd105;
  localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = 16'd6554;
  localparam logic [GAIN_W-1:0] RST_OUT_GAIN      = 16'd16384;

  localparam logic [STEP_W-1:0] STEP_MAX = 21'd1048576;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 16'd32768;

  // effective settings after clamping
  typedef struct packed {
    logic [DLY_W-1:0]  base_delay;
    logic [DLY_W-1:0]  depth;
    logic [STEP_W-1:0] step;
    logic [GAIN_W-1:0] fb_gain;
    logic [GAIN_W-1:0] out_gain;
  } cdm_cfg_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SAMPLE_W+2:0] v
  );
    logic signed [SAMPLE_W+2:0] hi;
    logic signed [SAMPLE_W+2:0] lo;
    hi = {4'b0000, {(SAMPLE_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/chorus_delay_modulator_top.sv
`timescale 1ns / 1ps

// Mono chorus, one result word per input word. A sample is accepted only
// while the sequencer is idle. Accepting it takes the word and steps the
// triangle LFO; eight sequencer steps then go through the single read
// port of the delay memory (two reads for the interpolation taps) and four
// registered multiplies (modulation, interpolation, feedback, output gain).
// The result sits in an output register, so the next sample is taken while the
// previous result still waits. The delay memory is not cleared after reset: a
// fill count tracks which entries were written and unwritten entries read as
// zero, so the block takes samples right after reset.
module chorus_delay_modulator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [cdm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                             in_block_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [cdm_pkg::SAMPLE_W-1:0] out_sample,
  output logic                             out_block_last_out,
  input  logic                             cfg_we,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cdm_pkg::*;

  localparam int SW   = SAMPLE_W;
  localparam int MP_W = PHASE_W + DLY_W + 1;
  localparam int IP_W = SW + 1 + DLY_FRAC + 1;
  localparam int FP_W = SW + GAIN_W + 1;
  localparam int OP_W = SW + 1 + GAIN_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_ADDR = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_DLY  = 4'd5;
  localparam logic [3:0] S_FB   = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic signed [MP_W-1:0] MOD_HALF = MP_W'(2**(PHASE_FRAC-1));
  localparam logic signed [IP_W-1:0] IP_HALF  = IP_W'(2**(DLY_FRAC-1));
  localparam logic signed [FP_W-1:0] FB_HALF  = FP_W'(2**(GAIN_FRAC-1));
  localparam logic signed [OP_W-1:0] OG_HALF  = OP_W'(2**GAIN_FRAC);

  function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] p,
                                                input logic [ADDR_W-1:0] k);
    logic [ADDR_W:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= (ADDR_W+1)'(DELAY_DEPTH)) begin
      s = s - (ADDR_W+1)'(DELAY_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  // entries wp+1 .. wp+count hold written data, everything once the line is full
  function automatic logic tap_written(input logic [ADDR_W-1:0] k,
                                       input logic [CNT_W-1:0]  cnt);
    return (cnt == CNT_W'(DELAY_DEPTH)) || (k != '0 && CNT_W'(k) <= cnt);
  endfunction

  cdm_cfg_t cfg;

  logic [3:0] state_r, state_nxt;
  logic       accept;
  logic       out_load;

  logic signed [SW-1:0]      x_r;
  logic                      last_r;
  logic signed [PHASE_W-1:0] phase;
  logic [ADDR_W-1:0]         wp_r;
  logic [CNT_W-1:0]          cnt_r;

  logic signed [MP_W-1:0] mod_prod_r;
  logic [ADDR_W-1:0]      addr_b_r;
  logic [DLY_FRAC-1:0]    frac_r;
  logic                   val_a_r, val_b_r;
  logic signed [SW-1:0]   a_r;
  logic signed [IP_W-1:0] ip_prod_r;
  logic signed [SW-1:0]   delayed_r;
  logic signed [FP_W-1:0] fb_prod_r;
  logic signed [OP_W-1:0] og_prod_r;

  logic signed [SW-1:0] out_sample_r;
  logic                 out_last_r;
  logic                 out_valid_r;

  // address stage
  logic signed [MP_W-1:0]    mod_rnd;
  logic signed [DLY_W+1:0]   mod_val;
  logic signed [DLY_W+2:0]   dly;
  logic [DLY_W:0]            dly_u;
  logic [DINT_W-1:0]         dint;
  logic [ADDR_W-1:0]         k_a, k_b;
  logic [ADDR_W-1:0]         addr_a;

  // datapath
  logic signed [SW-1:0]      b_tap;
  logic signed [SW:0]        diff;
  logic signed [DLY_FRAC:0]  frac_s;
  logic signed [IP_W-1:0]    ip_rnd;
  logic signed [SW+1:0]      dsum;
  logic signed [GAIN_W:0]    fb_s, og_s;
  logic signed [FP_W-1:0]    fb_rnd;
  logic signed [SW+2:0]      wsum;
  logic signed [SW-1:0]      wval;
  logic signed [SW:0]        mix;
  logic signed [OP_W-1:0]    og_rnd;
  logic signed [SW+2:0]      ysum;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [SW-1:0]        ram_rdata;

  cdm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cdm_lfo u_lfo (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .step    (cfg.step),
    .phase   (phase)
  );

  cdm_ram #(
    .WIDTH (SW),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (wval),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign ram_we   = (state_r == S_WR);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        state_nxt = S_MOD;
      end
      S_MOD:  state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_DLY;
      S_DLY:  state_nxt = S_FB;
      S_FB:   state_nxt = S_WR;
      S_WR:   state_nxt = S_OUT;
      S_OUT:  if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // read delay, Q11.8, and the two tap offsets
  always_comb begin
    mod_rnd = mod_prod_r + MOD_HALF;
    mod_val = $signed(mod_rnd[PHASE_FRAC+DLY_W+1:PHASE_FRAC]);
    dly     = $signed({3'b000, cfg.base_delay}) + (DLY_W+3)'(mod_val);
    if (dly < 0) begin
      dly = '0;
    end
    dly_u = dly[DLY_W:0];
    dint  = dly_u[DLY_W:DLY_FRAC];
    if (int'(dint) > DELAY_DEPTH - 1) begin
      k_a = ADDR_W'(DELAY_DEPTH - 1);
    end else begin
      k_a = ADDR_W'(dint);
    end
    k_b    = (k_a == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : k_a + 1'b1;
    addr_a = mod_add(wp_r, k_a);
  end

  assign ram_raddr = (state_r == S_ADDR) ? addr_a : addr_b_r;

  always_comb begin
    b_tap  = val_b_r ? $signed(ram_rdata) : '0;
    diff   = (SW+1)'(b_tap) - (SW+1)'(a_r);
    frac_s = $signed({1'b0, frac_r});
    ip_rnd = ip_prod_r + IP_HALF;
    dsum   = (SW+2)'(a_r) + ip_rnd[IP_W-1:DLY_FRAC];
    fb_s   = $signed({1'b0, cfg.fb_gain});
    og_s   = $signed({1'b0, cfg.out_gain});
    fb_rnd = fb_prod_r + FB_HALF;
    wsum   = (SW+3)'(x_r) + (SW+3)'($signed(fb_rnd[FP_W-1:GAIN_FRAC]));
    wval   = sat_sample(wsum);
    mix    = (SW+1)'(x_r) + (SW+1)'(delayed_r);
    og_rnd = og_prod_r + OG_HALF;
    ysum   = (SW+3)'($signed(og_rnd[OP_W-1:GAIN_FRAC+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        wp_r  <= (wp_r == '0) ? ADDR_W'(DELAY_DEPTH - 1) : wp_r - 1'b1;
        cnt_r <= (cnt_r == CNT_W'(DELAY_DEPTH)) ? cnt_r : cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_sample;
      last_r <= in_block_last;
    end
    if (state_r == S_MOD) begin
      mod_prod_r <= MP_W'(phase) * MP_W'($signed({1'b0, cfg.depth}));
    end
    if (state_r == S_ADDR) begin
      addr_b_r <= mod_add(wp_r, k_b);
      frac_r   <= dly_u[DLY_FRAC-1:0];
      val_a_r  <= tap_written(k_a, cnt_r);
      val_b_r  <= tap_written(k_b, cnt_r);
    end
    if (state_r == S_RDA) begin
      a_r <= val_a_r ? $signed(ram_rdata) : '0;
    end
    if (state_r == S_RDB) begin
      ip_prod_r <= IP_W'(diff) * IP_W'(frac_s);
    end
    if (state_r == S_DLY) begin
      delayed_r <= dsum[SW-1:0];
    end
    if (state_r == S_FB) begin
      fb_prod_r <= FP_W'(delayed_r) * FP_W'(fb_s);
    end
    if (state_r == S_WR) begin
      og_prod_r <= OP_W'(mix) * OP_W'(og_s);
    end
    if (out_load) begin
      out_sample_r <= sat_sample(ysum);
      out_last_r   <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample         = out_sample_r;
  assign out_block_last_out = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DELAY_DEPTH))
    else $error("fill count beyond line depth");

  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> wp_r == (($past(wp_r) == '0) ? ADDR_W'(DELAY_DEPTH - 1)
                                            : $past(wp_r) - 1'b1))
    else $error("write pointer did not step down after a line write");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("output word raised outside the output step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MOD && !in_stall == 1'b0)
    else $error("accepted word did not start the sequencer");

  a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(ram_raddr) < DELAY_DEPTH)
    else $error("delay line read address out of range");

endmodule

FILE: rtl/cdm_ram.sv
`timescale 1ns / 1ps

module cdm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cdm_cfg.sv
`timescale 1ns / 1ps

module cdm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cdm_pkg::cdm_cfg_t            cfg
);
  import cdm_pkg::*;

  logic [DLY_W-1:0]  base_delay_r;
  logic [DLY_W-1:0]  mod_depth_r;
  logic [STEP_W-1:0] lfo_step_r;
  logic [GAIN_W-1:0] fb_gain_r;
  logic [GAIN_W-1:0] out_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r <= RST_BASE_DELAY;
      mod_depth_r  <= RST_MOD_DEPTH;
      lfo_step_r   <= RST_LFO_STEP;
      fb_gain_r    <= RST_FEEDBACK_GAIN;
      out_gain_r   <= RST_OUT_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_DELAY:    base_delay_r <= cfg_wdata[DLY_W-1:0];
        REG_MOD_DEPTH:     mod_depth_r  <= cfg_wdata[DLY_W-1:0];
        REG_LFO_STEP:      lfo_step_r   <= cfg_wdata[STEP_W-1:0];
        REG_FEEDBACK_GAIN: fb_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_OUT_GAIN:      out_gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // depth never exceeds the centre delay, so the delay stays non-negative
  always_comb begin
    cfg.base_delay = base_delay_r;
    cfg.depth      = (mod_depth_r < base_delay_r) ? mod_depth_r : base_delay_r;
    cfg.step       = (lfo_step_r > STEP_MAX) ? STEP_MAX : lfo_step_r;
    cfg.fb_gain    = (fb_gain_r > GAIN_MAX) ? GAIN_MAX : fb_gain_r;
    cfg.out_gain   = (out_gain_r > GAIN_MAX) ? GAIN_MAX : out_gain_r;
  end

endmodule

FILE: rtl/cdm_lfo.sv
`timescale 1ns / 1ps

module cdm_lfo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  logic [cdm_pkg::STEP_W-1:0]         step,
  output logic signed [cdm_pkg::PHASE_W-1:0] phase
);
  import cdm_pkg::*;

  localparam logic signed [PHASE_W-1:0] ONE     = PHASE_W'(2**PHASE_FRAC);
  localparam logic signed [PHASE_W-1:0] TWO     = PHASE_W'(2**(PHASE_FRAC+1));
  localparam logic signed [PHASE_W-1:0] NEG_ONE = -ONE;
  localparam logic signed [PHASE_W-1:0] NEG_TWO = -TWO;

  logic signed [PHASE_W-1:0] phase_r, phase_nxt;
  logic                      falling_r, falling_nxt;
  logic signed [PHASE_W-1:0] step_s;
  logic signed [PHASE_W-1:0] sum;

  always_comb begin
    step_s      = $signed(PHASE_W'(step));
    sum         = falling_r ? (phase_r - step_s) : (phase_r + step_s);
    phase_nxt   = sum;
    falling_nxt = falling_r;
    // reflect at the bounds and turn around
    if (sum > ONE) begin
      phase_nxt   = TWO - sum;
      falling_nxt = !falling_r;
    end else if (sum < NEG_ONE) begin
      phase_nxt   = NEG_TWO - sum;
      falling_nxt = !falling_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      falling_r <= 1'b0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      falling_r <= falling_nxt;
    end
  end

  assign phase = phase_r;

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= ONE && phase_r >= NEG_ONE)
    else $error("lfo phase left [-1, 1]");

endmodule
